// ----- hdl/abff_pkg.sv -----
`default_nettype none

package abff_pkg;

  localparam int unsigned MAX_BITS = 1024;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_RESET_BITS = 1024;

  typedef enum logic [REQ_W-1:0] {
    REQ_TEST       = 3'd0,
    REQ_SET        = 3'd1,
    REQ_CLEAR      = 3'd2,
    REQ_FIND_SET   = 3'd3,
    REQ_FIND_CLEAR = 3'd4,
    REQ_CLEAR_ALL  = 3'd5,
    REQ_SET_ALL    = 3'd6,
    REQ_NONE       = 3'd7
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_NONE  = 2'd2
  } status_e;

  // operation of the shared word unit
  typedef enum logic [2:0] {
    WOP_TEST,
    WOP_SET_BIT,
    WOP_CLEAR_BIT,
    WOP_FIND_SET,
    WOP_FIND_CLEAR,
    WOP_FILL
  } wop_e;

  typedef struct packed {
    wop_e op;
  } word_ctl_t;

  typedef struct packed {
    logic hit;
    logic bit_val;
  } word_res_t;

endpackage

`default_nettype wire

// ----- hdl/abff_if.sv -----
`default_nettype none

interface abff_req_if;
  logic                          valid;
  logic                          ready;
  logic [abff_pkg::REQ_W-1:0]    req_type;
  logic [abff_pkg::INDEX_W-1:0]  bit_index;

  modport source (output valid, output req_type, output bit_index, input ready);
  modport sink   (input valid, input req_type, input bit_index, output ready);
endinterface

interface abff_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [abff_pkg::STATUS_W-1:0]  status;
  logic                           bit_value;
  logic [abff_pkg::INDEX_W-1:0]   found_index;
  logic                           all_clear;
  logic                           all_set;

  modport source (output valid, output status, output bit_value, output found_index,
                  output all_clear, output all_set, input ready);
  modport sink   (input valid, input status, input bit_value, input found_index,
                  input all_clear, input all_set, output ready);
endinterface

`default_nettype wire

// ----- hdl/abff_word_unit.sv -----
`default_nettype none

module abff_word_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]                 word_i,
  input  logic [$clog2(WORD_BITS+1)-1:0]       lim_i,
  input  logic [$clog2(WORD_BITS)-1:0]         pos_i,
  input  abff_pkg::word_ctl_t                  ctl_i,
  output logic [WORD_BITS-1:0]                 word_o,
  output logic [$clog2(WORD_BITS)-1:0]         hit_pos_o,
  output abff_pkg::word_res_t                  res_o
);

  localparam int unsigned POS_W = $clog2(WORD_BITS);
  localparam int unsigned LIM_W = $clog2(WORD_BITS+1);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;

  // bits of this word that lie below the bits-in-use limit
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (LIM_W'(b) < lim_i);
    end
  end

  assign cand = ((ctl_i.op == abff_pkg::WOP_FIND_SET) ? word_i : ~word_i) & mask;

  // lowest candidate wins
  always_comb begin
    hit_pos_o = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_pos_o = POS_W'(b);
      end
    end
  end

  always_comb begin
    res_o.hit     = |cand;
    res_o.bit_val = word_i[pos_i];
    word_o        = word_i;
    case (ctl_i.op)
      abff_pkg::WOP_SET_BIT:   word_o[pos_i] = 1'b1;
      abff_pkg::WOP_CLEAR_BIT: word_o[pos_i] = 1'b0;
      abff_pkg::WOP_FILL:      word_o        = word_i | mask;
      default:                 word_o        = word_i;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/allocation_bitmap_find_first.sv -----
// test, set and clear scan the store word by word up to the word that holds bit_index,
// finds up to a hit or the last word in use, and set-all fills every word in use;
// clear-all, out-of-range and no-op requests go straight to the result
// one item at a time, the next one taken the cycle after the result; the word scan
// shares one word unit, one store word per cycle
// reset (async, active low) clears the whole store and the set count and restores
// bits_in_use to 1024; a configuration write clears store and count
`default_nettype none

module allocation_bitmap_find_first #(
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [abff_pkg::CFG_W-1:0]    cfg_wdata_i,
  abff_req_if.sink                           req,
  abff_rsp_if.source                         rsp
);

  localparam int unsigned MAX_BITS  = abff_pkg::MAX_BITS;
  localparam int unsigned NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned POS_W     = $clog2(WORD_BITS);
  localparam int unsigned LIM_W     = $clog2(WORD_BITS + 1);
  localparam int unsigned CNT_W     = $clog2(MAX_BITS + 1);
  localparam int unsigned NW        = (CNT_W > abff_pkg::CFG_W) ? CNT_W : abff_pkg::CFG_W;
  localparam int unsigned RESET_BITS =
    (abff_pkg::CFG_RESET_BITS > MAX_BITS) ? MAX_BITS : abff_pkg::CFG_RESET_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [WORD_BITS-1:0]             store_q [NUM_WORDS];
  logic [CNT_W-1:0]                 n_q;
  logic [CNT_W-1:0]                 count_q, count_d;
  logic [WADDR_W-1:0]               waddr_q, waddr_d;
  logic [CNT_W-1:0]                 base_q, base_d;
  abff_pkg::req_e                   op_q, op_d;
  logic [abff_pkg::INDEX_W-1:0]     idx_q, idx_d;
  abff_pkg::status_e                status_q, status_d;
  logic                             bit_q, bit_d;
  logic [abff_pkg::INDEX_W-1:0]     found_q, found_d;

  logic                             accept;
  logic                             clear_all;
  logic                             store_we;
  logic [NW-1:0]                    cfg_ext;
  logic [NW-1:0]                    n_clamped;
  logic [CNT_W-1:0]                 rem;
  logic [LIM_W-1:0]                 lim;
  logic                             last_word;
  logic [NW-1:0]                    off;
  logic                             target_word;
  logic [NW-1:0]                    found_sum;
  logic [WORD_BITS-1:0]             unit_word;
  logic [POS_W-1:0]                 unit_hit_pos;
  abff_pkg::word_ctl_t              unit_ctl;
  abff_pkg::word_res_t              unit_res;

  assign accept = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);

  assign cfg_ext = NW'(cfg_wdata_i);
  always_comb begin
    if (cfg_ext == '0) begin
      n_clamped = NW'(1);
    end else if (cfg_ext > NW'(MAX_BITS)) begin
      n_clamped = NW'(MAX_BITS);
    end else begin
      n_clamped = cfg_ext;
    end
  end

  // limit of the word under scan, relative to its first bit
  assign rem       = n_q - base_q;
  assign last_word = (rem <= CNT_W'(WORD_BITS));
  assign lim       = last_word ? LIM_W'(rem) : LIM_W'(WORD_BITS);
  assign off       = NW'(idx_q) - NW'(base_q);
  assign target_word = (off < NW'(WORD_BITS));
  assign found_sum = NW'(base_q) + NW'(unit_hit_pos);

  always_comb begin
    case (op_q)
      abff_pkg::REQ_SET:        unit_ctl.op = abff_pkg::WOP_SET_BIT;
      abff_pkg::REQ_CLEAR:      unit_ctl.op = abff_pkg::WOP_CLEAR_BIT;
      abff_pkg::REQ_FIND_SET:   unit_ctl.op = abff_pkg::WOP_FIND_SET;
      abff_pkg::REQ_FIND_CLEAR: unit_ctl.op = abff_pkg::WOP_FIND_CLEAR;
      abff_pkg::REQ_SET_ALL:    unit_ctl.op = abff_pkg::WOP_FILL;
      default:                  unit_ctl.op = abff_pkg::WOP_TEST;
    endcase
  end

  abff_word_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_word_unit (
    .word_i    (store_q[waddr_q]),
    .lim_i     (lim),
    .pos_i     (off[POS_W-1:0]),
    .ctl_i     (unit_ctl),
    .word_o    (unit_word),
    .hit_pos_o (unit_hit_pos),
    .res_o     (unit_res)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    waddr_d   = waddr_q;
    base_d    = base_q;
    op_d      = op_q;
    idx_d     = idx_q;
    status_d  = status_q;
    bit_d     = bit_q;
    found_d   = found_q;
    clear_all = 1'b0;
    store_we  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = abff_pkg::req_e'(req.req_type);
          idx_d    = req.bit_index;
          waddr_d  = '0;
          base_d   = '0;
          status_d = abff_pkg::STAT_OK;
          bit_d    = 1'b0;
          found_d  = '0;
          state_d  = S_SCAN;
          case (abff_pkg::req_e'(req.req_type))
            abff_pkg::REQ_TEST, abff_pkg::REQ_SET, abff_pkg::REQ_CLEAR: begin
              if (NW'(req.bit_index) >= NW'(n_q)) begin
                status_d = abff_pkg::STAT_RANGE;
                state_d  = S_OUT;
              end
            end
            abff_pkg::REQ_CLEAR_ALL: begin
              clear_all = 1'b1;
              count_d   = '0;
              state_d   = S_OUT;
            end
            abff_pkg::REQ_NONE: begin
              state_d = S_OUT;
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        case (op_q)
          abff_pkg::REQ_FIND_SET, abff_pkg::REQ_FIND_CLEAR: begin
            if (unit_res.hit) begin
              found_d = found_sum[abff_pkg::INDEX_W-1:0];
              state_d = S_OUT;
            end else if (last_word) begin
              status_d = abff_pkg::STAT_NONE;
              state_d  = S_OUT;
            end
          end
          abff_pkg::REQ_SET_ALL: begin
            store_we = 1'b1;
            if (last_word) begin
              count_d = n_q;
              state_d = S_OUT;
            end
          end
          default: begin
            if (target_word) begin
              bit_d    = unit_res.bit_val;
              store_we = 1'b1;
              if (op_q == abff_pkg::REQ_SET && !unit_res.bit_val) begin
                count_d = count_q + CNT_W'(1);
              end else if (op_q == abff_pkg::REQ_CLEAR && unit_res.bit_val) begin
                count_d = count_q - CNT_W'(1);
              end
              state_d = S_OUT;
            end
          end
        endcase
        if (state_d == S_SCAN) begin
          waddr_d = waddr_q + WADDR_W'(1);
          base_d  = base_q + CNT_W'(WORD_BITS);
        end
      end
      S_OUT: begin
        if (rsp.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= CNT_W'(RESET_BITS);
      count_q <= '0;
      waddr_q <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      waddr_q <= waddr_d;
      base_q  <= base_d;
      if (cfg_we_i) begin
        n_q     <= CNT_W'(n_clamped);
        count_q <= '0;
      end else begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        store_q[w] <= '0;
      end
    end else if (cfg_we_i || clear_all) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        store_q[w] <= '0;
      end
    end else if (store_we) begin
      store_q[waddr_q] <= unit_word;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    bit_q    <= bit_d;
    found_q  <= found_d;
  end

  assign rsp.valid       = (state_q == S_OUT);
  assign rsp.status      = status_q;
  assign rsp.bit_value   = bit_q;
  assign rsp.found_index = found_q;
  assign rsp.all_clear   = (count_q == '0);
  assign rsp.all_set     = (count_q == n_q);

endmodule

`default_nettype wire

// ----- sim/abff_sb_pkg.sv -----
`timescale 1ns / 1ps

package abff_sb_pkg;

  localparam int unsigned MAP_BITS = abff_pkg::MAX_BITS;

  typedef struct {
    abff_pkg::status_e                  status;
    logic                               bit_value;
    logic [abff_pkg::INDEX_W-1:0]       found_index;
    logic                               all_clear;
    logic                               all_set;
  } bitmap_rsp_t;

  class bitmap_scoreboard;
    bit [MAP_BITS-1:0]  alloc_flags;
    int unsigned        set_count;
    int unsigned        limit_reg;
    bitmap_rsp_t        expected_rsp_q[$];
    int unsigned        mismatches;

    function new();
      alloc_flags = '0;
      set_count   = 0;
      limit_reg   = abff_pkg::CFG_RESET_BITS;
      mismatches  = 0;
    endfunction

    // register value as the map sees it: 0 acts as 1, above the map size acts as full
    function int unsigned used_bits();
      if (limit_reg < 1) return 1;
      if (limit_reg > MAP_BITS) return MAP_BITS;
      return limit_reg;
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction

    function void write_limit(logic [abff_pkg::CFG_W-1:0] value);
      limit_reg   = value;
      alloc_flags = '0;
      set_count   = 0;
    endfunction

    function void note_request(abff_pkg::req_e rq, logic [abff_pkg::INDEX_W-1:0] idx);
      bitmap_rsp_t  exp;
      int unsigned  n;
      bit           want;
      n               = used_bits();
      exp.status      = abff_pkg::STAT_OK;
      exp.bit_value   = 1'b0;
      exp.found_index = '0;
      case (rq)
        abff_pkg::REQ_TEST, abff_pkg::REQ_SET, abff_pkg::REQ_CLEAR: begin
          if (idx >= n) begin
            exp.status = abff_pkg::STAT_RANGE;
          end else begin
            exp.bit_value = alloc_flags[idx];
            if (rq == abff_pkg::REQ_SET && !alloc_flags[idx]) begin
              alloc_flags[idx] = 1'b1;
              set_count++;
            end else if (rq == abff_pkg::REQ_CLEAR && alloc_flags[idx]) begin
              alloc_flags[idx] = 1'b0;
              set_count--;
            end
          end
        end
        abff_pkg::REQ_FIND_SET, abff_pkg::REQ_FIND_CLEAR: begin
          want       = (rq == abff_pkg::REQ_FIND_SET);
          exp.status = abff_pkg::STAT_NONE;
          for (int i = 0; i < n; i++) begin
            if (alloc_flags[i] == want) begin
              exp.status      = abff_pkg::STAT_OK;
              exp.found_index = abff_pkg::INDEX_W'(i);
              break;
            end
          end
        end
        abff_pkg::REQ_CLEAR_ALL: begin
          alloc_flags = '0;
          set_count   = 0;
        end
        abff_pkg::REQ_SET_ALL: begin
          for (int i = 0; i < n; i++) alloc_flags[i] = 1'b1;
          set_count = n;
        end
        default: ;
      endcase
      exp.all_clear = (set_count == 0);
      exp.all_set   = (set_count == n);
      expected_rsp_q.push_back(exp);
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_response(bitmap_rsp_t got);
      bitmap_rsp_t exp;
      if (expected_rsp_q.size() == 0) begin
        report("result with no request pending");
        return;
      end
      exp = expected_rsp_q.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.bit_value !== exp.bit_value)
        report($sformatf("bit_value %0b, expected %0b", got.bit_value, exp.bit_value));
      if (got.found_index !== exp.found_index)
        report($sformatf("found_index %0d, expected %0d", got.found_index,
                         exp.found_index));
      if (got.all_clear !== exp.all_clear)
        report($sformatf("all_clear %0b, expected %0b", got.all_clear, exp.all_clear));
      if (got.all_set !== exp.all_set)
        report($sformatf("all_set %0b, expected %0b", got.all_set, exp.all_set));
    endtask
  endclass

endpackage

// ----- sim/allocation_bitmap_find_first_tb.sv -----
`timescale 1ns / 1ps

module allocation_bitmap_find_first_tb;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [abff_pkg::CFG_W-1:0]     cfg_wdata;
  bit                             idle_on;
  abff_sb_pkg::bitmap_scoreboard  sb;
  abff_sb_pkg::bitmap_rsp_t       seen_rsp;

  abff_req_if req_ch ();
  abff_rsp_if rsp_ch ();

  allocation_bitmap_find_first i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // result stalls in bursts
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 12);
      if (stall_left != 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      seen_rsp.status      = abff_pkg::status_e'(rsp_ch.status);
      seen_rsp.bit_value   = rsp_ch.bit_value;
      seen_rsp.found_index = rsp_ch.found_index;
      seen_rsp.all_clear   = rsp_ch.all_clear;
      seen_rsp.all_set     = rsp_ch.all_set;
      sb.check_response(seen_rsp);
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task issue_request(abff_pkg::req_e rq, logic [abff_pkg::INDEX_W-1:0] idx);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.req_type  = rq;
    req_ch.bit_index = idx;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(rq, idx);
    @(negedge clk);
  endtask

  task drain;
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // let the scan finish before touching the register
    repeat (20) @(negedge clk);
  endtask

  task write_bits_in_use(logic [abff_pkg::CFG_W-1:0] value);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    sb.write_limit(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [abff_pkg::INDEX_W-1:0] pick_index(int unsigned n);
    case ($urandom_range(0, 9))
      0: return abff_pkg::INDEX_W'($urandom_range(0, 1023));
      1: return (n > 1023) ? abff_pkg::INDEX_W'(1023)
                           : abff_pkg::INDEX_W'(n - $urandom_range(0, 1));
      default: return abff_pkg::INDEX_W'($urandom_range(0, n - 1));
    endcase
  endfunction

  task random_items(int unsigned count);
    int unsigned    n;
    int unsigned    pick;
    abff_pkg::req_e rq;
    n = sb.used_bits();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      rq = abff_pkg::REQ_TEST;
      else if (pick < 42) rq = abff_pkg::REQ_SET;
      else if (pick < 62) rq = abff_pkg::REQ_CLEAR;
      else if (pick < 74) rq = abff_pkg::REQ_FIND_SET;
      else if (pick < 86) rq = abff_pkg::REQ_FIND_CLEAR;
      else if (pick < 90) rq = abff_pkg::REQ_CLEAR_ALL;
      else if (pick < 95) rq = abff_pkg::REQ_SET_ALL;
      else                rq = abff_pkg::REQ_NONE;
      issue_request(rq, pick_index(n));
    end
  endtask

  initial begin
    sb               = new();
    rst_n            = 1'b0;
    idle_on          = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = abff_pkg::REQ_TEST;
    req_ch.bit_index = '0;
    repeat (7) @(negedge clk);
    rst_n   = 1'b1;
    idle_on = 1'b1;
    @(negedge clk);

    // empty map, full size
    issue_request(abff_pkg::REQ_FIND_SET, 10'd0);
    issue_request(abff_pkg::REQ_FIND_CLEAR, 10'd0);
    issue_request(abff_pkg::REQ_TEST, 10'd1023);
    issue_request(abff_pkg::REQ_SET, 10'd1023);
    issue_request(abff_pkg::REQ_SET, 10'd1023);
    issue_request(abff_pkg::REQ_CLEAR, 10'd0);
    issue_request(abff_pkg::REQ_FIND_SET, 10'd0);
    issue_request(abff_pkg::REQ_SET, 10'd0);
    issue_request(abff_pkg::REQ_FIND_SET, 10'd0);
    issue_request(abff_pkg::REQ_CLEAR, 10'd0);
    issue_request(abff_pkg::REQ_TEST, 10'd0);
    issue_request(abff_pkg::REQ_SET_ALL, 10'd0);
    issue_request(abff_pkg::REQ_FIND_CLEAR, 10'd0);
    issue_request(abff_pkg::REQ_TEST, 10'd512);
    issue_request(abff_pkg::REQ_CLEAR, 10'd700);
    issue_request(abff_pkg::REQ_FIND_CLEAR, 10'd0);
    issue_request(abff_pkg::REQ_NONE, 10'd1023);
    issue_request(abff_pkg::REQ_CLEAR_ALL, 10'd0);
    issue_request(abff_pkg::REQ_TEST, 10'd700);

    // zero acts as a one-bit map
    write_bits_in_use(11'd0);
    issue_request(abff_pkg::REQ_SET, 10'd1);
    issue_request(abff_pkg::REQ_SET, 10'd0);
    issue_request(abff_pkg::REQ_FIND_CLEAR, 10'd0);
    issue_request(abff_pkg::REQ_TEST, 10'd1023);
    issue_request(abff_pkg::REQ_CLEAR, 10'd0);

    // all ones acts as the full map
    write_bits_in_use(11'd2047);
    random_items(140);
    write_bits_in_use(11'd1);
    random_items(60);
    write_bits_in_use(11'd64);
    random_items(140);
    write_bits_in_use(11'd65);
    random_items(140);
    write_bits_in_use(abff_pkg::CFG_W'($urandom_range(2, 1023)));
    random_items(140);
    write_bits_in_use(11'd1000);
    random_items(140);
    idle_on = 1'b0;
    write_bits_in_use(11'd1024);
    random_items(100);

    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- allocation_bitmap_find_first.f -----
hdl/abff_pkg.sv
hdl/abff_if.sv
hdl/abff_word_unit.sv
hdl/allocation_bitmap_find_first.sv
sim/abff_sb_pkg.sv
sim/allocation_bitmap_find_first_tb.sv
